// ===== design/rbg_pkg.sv =====
// ---------------------------------------------------------------------------
// rbg_pkg: shared types and constants for the resource budget governor
// Item and result layouts, operating modes, governor states and limits.
// ---------------------------------------------------------------------------
package rbg_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 16;

  // Page size in kilobytes
  localparam logic [DATA_W-1:0] PAGE_KB = 32'd4;

  localparam logic [CNT_W-1:0] CPU_SAFE_LIMIT = 16'd3;
  localparam logic [CNT_W-1:0] MEM_SAFE_LIMIT = 16'd2;
  localparam logic [CNT_W-1:0] CNT_MAX        = 16'hFFFF;
  localparam logic [DATA_W-1:0] USAGE_MAX     = 32'hFFFF_FFFF;

  // Register indexes on the configuration port
  localparam logic REG_CPU_LIMIT  = 1'b0;
  localparam logic REG_MEM_BUDGET = 1'b1;

  typedef enum logic [1:0] {
    MODE_CPU   = 2'd0,
    MODE_MEM   = 2'd1,
    MODE_ALLOC = 2'd2,
    MODE_FREE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_WARNED = 2'd1,
    ST_SAFE   = 2'd2
  } gov_state_t;

  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] amount;
    logic              alloc_ok;
    logic              addr_nonzero;
  } item_t;

  typedef struct packed {
    logic              violation;
    logic              granted;
    logic [1:0]        contract_state;
    logic              can_run;
    logic [DATA_W-1:0] cpu_used_total;
    logic [DATA_W-1:0] mem_used_total;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] cpu_limit;
    logic [DATA_W-1:0] memory_budget;
  } budgets_t;

endpackage

// ===== design/rbg_cfg.sv =====
// ---------------------------------------------------------------------------
// rbg_cfg: budget registers behind the APB-style configuration port
// Holds the CPU and memory budgets; reads return the register contents.
// ---------------------------------------------------------------------------
module rbg_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [2:0]                 cfg_paddr,
  input  logic [rbg_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [rbg_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output rbg_pkg::budgets_t          budgets
);

  logic [rbg_pkg::DATA_W-1:0] cpu_limit_r;
  logic [rbg_pkg::DATA_W-1:0] mem_budget_r;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Only the word select bit is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_limit_r  <= '0;
      mem_budget_r <= '0;
    end else if (wr_en) begin
      if (cfg_paddr[2] == rbg_pkg::REG_CPU_LIMIT) begin
        cpu_limit_r <= cfg_pwdata;
      end else begin
        mem_budget_r <= cfg_pwdata;
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == rbg_pkg::REG_CPU_LIMIT) begin
      cfg_prdata = cpu_limit_r;
    end else begin
      cfg_prdata = mem_budget_r;
    end
  end

  assign budgets.cpu_limit     = cpu_limit_r;
  assign budgets.memory_budget = mem_budget_r;

endmodule

// ===== design/rbg_core.sv =====
// ---------------------------------------------------------------------------
// rbg_core: usage accounting and governor state
// Applies one item per cycle, when item_en is set, to the usage, counters and governor state.
// ---------------------------------------------------------------------------
module rbg_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_en,
  input  rbg_pkg::item_t    item,
  input  rbg_pkg::budgets_t budgets,
  output rbg_pkg::result_t  result
);

  logic [rbg_pkg::DATA_W-1:0] cpu_used_r, cpu_used_nxt;
  logic [rbg_pkg::DATA_W-1:0] mem_used_r, mem_used_nxt;
  logic [rbg_pkg::CNT_W-1:0]  cpu_cnt_r, cpu_cnt_nxt;
  logic [rbg_pkg::CNT_W-1:0]  mem_cnt_r, mem_cnt_nxt;
  rbg_pkg::gov_state_t        state_r, state_nxt;

  logic [rbg_pkg::DATA_W:0]   cpu_sum;
  logic [rbg_pkg::DATA_W:0]   mem_sum;
  logic [rbg_pkg::DATA_W-1:0] mem_operand;
  logic [rbg_pkg::DATA_W-1:0] cpu_sat;
  logic [rbg_pkg::DATA_W-1:0] mem_sat;
  logic [rbg_pkg::CNT_W-1:0]  cpu_cnt_inc;
  logic [rbg_pkg::CNT_W-1:0]  mem_cnt_inc;
  logic                       cpu_viol;
  logic                       mem_viol;
  logic                       granted;

  // One adder per usage; page requests share the memory adder
  assign mem_operand = (item.mode == rbg_pkg::MODE_ALLOC) ? rbg_pkg::PAGE_KB : item.amount;
  assign cpu_sum     = {1'b0, cpu_used_r} + {1'b0, item.amount};
  assign mem_sum     = {1'b0, mem_used_r} + {1'b0, mem_operand};
  assign cpu_sat     = cpu_sum[rbg_pkg::DATA_W] ? rbg_pkg::USAGE_MAX
                                                : cpu_sum[rbg_pkg::DATA_W-1:0];
  assign mem_sat     = mem_sum[rbg_pkg::DATA_W] ? rbg_pkg::USAGE_MAX
                                                : mem_sum[rbg_pkg::DATA_W-1:0];
  assign cpu_cnt_inc = (cpu_cnt_r == rbg_pkg::CNT_MAX) ? cpu_cnt_r : cpu_cnt_r + 1'b1;
  assign mem_cnt_inc = (mem_cnt_r == rbg_pkg::CNT_MAX) ? mem_cnt_r : mem_cnt_r + 1'b1;

  // Usage and violation accounting
  always_comb begin
    cpu_used_nxt = cpu_used_r;
    mem_used_nxt = mem_used_r;
    cpu_viol     = 1'b0;
    mem_viol     = 1'b0;
    granted      = 1'b0;
    unique case (item.mode)
      rbg_pkg::MODE_CPU: begin
        cpu_used_nxt = cpu_sat;
        cpu_viol     = cpu_sat > budgets.cpu_limit;
      end
      rbg_pkg::MODE_MEM: begin
        mem_used_nxt = mem_sat;
        mem_viol     = mem_sat > budgets.memory_budget;
      end
      rbg_pkg::MODE_ALLOC: begin
        if (state_r != rbg_pkg::ST_SAFE) begin
          // exact 33-bit sum, no wrap
          if (mem_sum > {1'b0, budgets.memory_budget}) begin
            mem_viol = 1'b1;
          end else if (item.alloc_ok) begin
            mem_used_nxt = mem_sum[rbg_pkg::DATA_W-1:0];
            granted      = 1'b1;
          end
        end
      end
      rbg_pkg::MODE_FREE: begin
        if (item.addr_nonzero && (mem_used_r >= rbg_pkg::PAGE_KB)) begin
          mem_used_nxt = mem_used_r - rbg_pkg::PAGE_KB;
        end
      end
      default: begin
      end
    endcase
    cpu_cnt_nxt = cpu_viol ? cpu_cnt_inc : cpu_cnt_r;
    mem_cnt_nxt = mem_viol ? mem_cnt_inc : mem_cnt_r;
  end

  // Governor state: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbg_pkg::ST_OK: begin
        if (cpu_viol || mem_viol) begin
          state_nxt = rbg_pkg::ST_WARNED;
        end
      end
      rbg_pkg::ST_WARNED: begin
        if ((cpu_viol && (cpu_cnt_nxt >= rbg_pkg::CPU_SAFE_LIMIT)) ||
            (mem_viol && (mem_cnt_nxt >= rbg_pkg::MEM_SAFE_LIMIT))) begin
          state_nxt = rbg_pkg::ST_SAFE;
        end
      end
      rbg_pkg::ST_SAFE: begin
        state_nxt = rbg_pkg::ST_SAFE;
      end
      default: begin
        state_nxt = rbg_pkg::ST_OK;
      end
    endcase
  end

  // Governor state: outputs
  always_comb begin
    result.violation      = cpu_viol | mem_viol;
    result.granted        = granted;
    result.contract_state = state_nxt;
    result.can_run        = (state_nxt != rbg_pkg::ST_SAFE);
    result.cpu_used_total = cpu_used_nxt;
    result.mem_used_total = mem_used_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_used_r <= '0;
      mem_used_r <= '0;
      cpu_cnt_r  <= '0;
      mem_cnt_r  <= '0;
      state_r    <= rbg_pkg::ST_OK;
    end else if (item_en) begin
      cpu_used_r <= cpu_used_nxt;
      mem_used_r <= mem_used_nxt;
      cpu_cnt_r  <= cpu_cnt_nxt;
      mem_cnt_r  <= mem_cnt_nxt;
      state_r    <= state_nxt;
    end
  end

endmodule

// ===== design/resource_budget_governor_top.sv =====
// ---------------------------------------------------------------------------
// resource_budget_governor_top: CPU and memory budget governor
// Stream in, stream out, APB-style budget registers.
// ---------------------------------------------------------------------------
// Takes one item per clock while the output is not held and returns one result per
// item, through an input register, then the usage update and result register. The
// rate of one item a cycle is set by the read-modify-write of the usage registers
// and governor state.
// Budgets are to be written through the configuration port only while no item
// is in flight; the block does not enforce this. Both reset to zero.
module resource_budget_governor_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // amount[31:0], alloc_ok[32], addr_nonzero[33], zero pad
  input  logic [1:0]  in_tuser,   // mode[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // violation[0], granted[1], contract_state[3:2], can_run[4],
  // cpu_used_total[36:5], mem_used_total[68:37], zero pad
  output logic [71:0] out_tdata,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  rbg_pkg::budgets_t budgets;
  rbg_pkg::item_t    item_r;
  rbg_pkg::result_t  res;
  rbg_pkg::result_t  res_r;
  logic              in_vld_r;
  logic              out_vld_r;
  logic              advance;

  rbg_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .budgets     (budgets)
  );

  rbg_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (advance),
    .item    (item_r),
    .budgets (budgets),
    .result  (res)
  );

  // item moves into the result register when that register is free or draining
  assign advance   = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.mode         <= rbg_pkg::mode_t'(in_tuser);
      item_r.amount       <= in_tdata[31:0];
      item_r.alloc_ok     <= in_tdata[32];
      item_r.addr_nonzero <= in_tdata[33];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, res_r.mem_used_total, res_r.cpu_used_total, res_r.can_run,
                       res_r.contract_state, res_r.granted, res_r.violation};

  // A granted page comes only from an allocation request and never with a violation
  a_grant_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.granted |-> (item_r.mode == rbg_pkg::MODE_ALLOC) && !res.violation)
    else $error("grant outside a clean allocation");

  // Safe mode denies every page
  a_safe_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res.contract_state == rbg_pkg::ST_SAFE) |-> !res.granted)
    else $error("page granted in safe mode");

  // A held item stays put until it moves on
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(item_r))
    else $error("held item lost or changed");

endmodule

// ===== dv/governor_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// governor_checker: result checker for the resource budget governor
// Watches the item, result and budget ports, keeps its own copy of the usage,
// violation counts and governor state, and compares every result field.
// ---------------------------------------------------------------------------
module governor_checker
  import rbg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          outstanding
);

  logic [DATA_W-1:0] cpu_limit;
  logic [DATA_W-1:0] mem_limit;
  logic [DATA_W-1:0] cpu_spent;
  logic [DATA_W-1:0] mem_held;
  logic [CNT_W-1:0]  cpu_strikes;
  logic [CNT_W-1:0]  mem_strikes;
  gov_state_t        gstate;
  result_t           outcome_q[$];

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DATA_W] ? USAGE_MAX : sum[DATA_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

  task automatic escalate(input logic [CNT_W-1:0] strikes, input logic [CNT_W-1:0] limit);
    if (gstate == ST_OK) begin
      gstate = ST_WARNED;
    end else if (gstate == ST_WARNED && strikes >= limit) begin
      gstate = ST_SAFE;
    end
  endtask

  task automatic govern(input item_t it, output result_t r);
    logic [DATA_W:0] want;
    r = '0;
    case (it.mode)
      MODE_CPU: begin
        cpu_spent = sat_add(cpu_spent, it.amount);
        if (cpu_spent > cpu_limit) begin
          r.violation = 1'b1;
          cpu_strikes = bump(cpu_strikes);
          escalate(cpu_strikes, CPU_SAFE_LIMIT);
        end
      end
      MODE_MEM: begin
        mem_held = sat_add(mem_held, it.amount);
        if (mem_held > mem_limit) begin
          r.violation = 1'b1;
          mem_strikes = bump(mem_strikes);
          escalate(mem_strikes, MEM_SAFE_LIMIT);
        end
      end
      MODE_ALLOC: begin
        // unwrapped sum, so a page near the top of the range still overruns
        if (gstate != ST_SAFE) begin
          want = {1'b0, mem_held} + {1'b0, PAGE_KB};
          if (want > {1'b0, mem_limit}) begin
            r.violation = 1'b1;
            mem_strikes = bump(mem_strikes);
            escalate(mem_strikes, MEM_SAFE_LIMIT);
          end else if (it.alloc_ok) begin
            mem_held  = sat_add(mem_held, PAGE_KB);
            r.granted = 1'b1;
          end
        end
      end
      default: begin
        if (it.addr_nonzero && mem_held >= PAGE_KB) begin
          mem_held = mem_held - PAGE_KB;
        end
      end
    endcase
    r.contract_state = gstate;
    r.can_run        = (gstate != ST_SAFE);
    r.cpu_used_total = cpu_spent;
    r.mem_used_total = mem_held;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    item_t   it;
    result_t want;
    result_t got;
    if (!rst_n) begin
      cpu_limit   = '0;
      mem_limit   = '0;
      cpu_spent   = '0;
      mem_held    = '0;
      cpu_strikes = '0;
      mem_strikes = '0;
      gstate      = ST_OK;
      outcome_q.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_MEM_BUDGET) begin
          mem_limit = cfg_pwdata;
        end else begin
          cpu_limit = cfg_pwdata;
        end
      end
      if (out_tvalid && out_tready) begin
        got.violation      = out_tdata[0];
        got.granted        = out_tdata[1];
        got.contract_state = out_tdata[3:2];
        got.can_run        = out_tdata[4];
        got.cpu_used_total = out_tdata[36:5];
        got.mem_used_total = out_tdata[68:37];
        if (outcome_q.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("violation", want.violation, got.violation);
          check_field("granted", want.granted, got.granted);
          check_field("contract_state", want.contract_state, got.contract_state);
          check_field("can_run", want.can_run, got.can_run);
          check_field("cpu_used_total", want.cpu_used_total, got.cpu_used_total);
          check_field("mem_used_total", want.mem_used_total, got.mem_used_total);
        end
      end
      if (in_tvalid && in_tready) begin
        it.mode         = mode_t'(in_tuser);
        it.amount       = in_tdata[31:0];
        it.alloc_ok     = in_tdata[32];
        it.addr_nonzero = in_tdata[33];
        govern(it, want);
        outcome_q.push_back(want);
      end
      outstanding = outcome_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for the resource budget governor
// Directed items through the OK, WARNED and safe mode states and the page
// edge cases, random traffic under several budgets, saturation and a run of
// back-to-back violations; results are checked by governor_checker.
// ---------------------------------------------------------------------------
module tb;
  import rbg_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int LIMIT_NS    = 200_000;
  localparam int FLOOD_ITEMS = 16;

  localparam logic [2:0] CPU_LIMIT_ADDR  = {REG_CPU_LIMIT, 2'b00};
  localparam logic [2:0] MEM_BUDGET_ADDR = {REG_MEM_BUDGET, 2'b00};

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_style_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // amount[31:0], alloc_ok[32], addr_nonzero[33], zero pad
  logic [1:0]  in_tuser;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready;
  // violation[0], granted[1], contract_state[3:2], can_run[4],
  // cpu_used_total[36:5], mem_used_total[68:37], zero pad
  logic [71:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatches;
  int          outstanding;

  logic        no_gaps;
  int          burst_left;
  logic        hold_start;
  logic        hold_seen;

  resource_budget_governor_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  governor_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("tb failed");
    $finish;
  end

  // Receiver: changes stall pattern every so often; one long hold-off on request
  initial begin : receiver
    rx_style_t  rx_style;
    int         rx_left;
    logic [7:0] rx_phase;
    rx_style   = RX_OPEN;
    rx_left    = 0;
    rx_phase   = '0;
    hold_seen  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_seen) begin
        hold_seen = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (rx_left == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        rx_left  = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_style)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_tready <= ($urandom_range(0, 9) != 0);
        default:   out_tready <= (rx_phase[1:0] != 2'd3);
      endcase
    end
  end

  task automatic offer(input mode_t mode, input logic [31:0] amount,
                       input logic alloc_ok, input logic addr_nz);
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, addr_nz, alloc_ok, amount};
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // wide: amounts over the full range, else small so budgets hold
  task automatic offer_random(input logic wide);
    logic [31:0] amount;
    amount = wide ? $urandom : $urandom_range(0, 1023);
    offer(mode_t'($urandom_range(0, 3)), amount, 1'($urandom_range(0, 1)),
          1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_budget(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = MODE_CPU;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    no_gaps     = 1'b0;
    burst_left  = 0;
    hold_start  = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // budgets still at reset: zero charges pass, frees with nothing held do nothing
    offer(MODE_CPU, 32'd0, 1'b0, 1'b0);
    offer(MODE_MEM, 32'd0, 1'b1, 1'b1);
    offer(MODE_FREE, 32'd0, 1'b0, 1'b1);
    offer(MODE_FREE, 32'hFFFF_FFFF, 1'b1, 1'b0);
    drain();

    // small budgets: exact-boundary charges and pages, allocator failure, frees
    write_budget(CPU_LIMIT_ADDR, 32'd100);
    write_budget(MEM_BUDGET_ADDR, 32'd8);
    offer(MODE_CPU, 32'd100, 1'b0, 1'b0);
    offer(MODE_ALLOC, 32'd0, 1'b1, 1'b0);
    offer(MODE_ALLOC, 32'd0, 1'b0, 1'b1);
    offer(MODE_ALLOC, 32'd0, 1'b1, 1'b0);
    offer(MODE_FREE, 32'd0, 1'b1, 1'b0);
    offer(MODE_FREE, 32'd0, 1'b0, 1'b1);
    offer(MODE_MEM, 32'd4, 1'b0, 1'b0);
    offer(MODE_FREE, 32'd0, 1'b0, 1'b1);
    offer(MODE_FREE, 32'd0, 1'b0, 1'b1);
    offer(MODE_FREE, 32'd0, 1'b0, 1'b1);
    offer(MODE_MEM, 32'd3, 1'b0, 1'b0);
    offer(MODE_FREE, 32'd0, 1'b0, 1'b1);
    drain();

    // roomy budgets, OK state throughout
    write_budget(CPU_LIMIT_ADDR, 32'h0100_0000);
    write_budget(MEM_BUDGET_ADDR, 32'h0100_0000);
    for (int i = 0; i < 600; i++) begin
      if (i == 300) begin
        hold_start = 1'b1;
        no_gaps    = 1'b1;
      end
      if (i == 360 || i == 520) no_gaps = 1'b0;
      if (i == 450) no_gaps = 1'b1;
      offer_random(1'b0);
    end
    drain();

    // first page overrun moves to WARNED; one cpu strike does not escalate
    write_budget(MEM_BUDGET_ADDR, 32'd0);
    offer(MODE_ALLOC, 32'd0, 1'b1, 1'b0);
    drain();
    write_budget(MEM_BUDGET_ADDR, 32'hFFFF_FFFF);
    write_budget(CPU_LIMIT_ADDR, 32'd0);
    offer(MODE_CPU, 32'd0, 1'b0, 1'b0);
    drain();
    write_budget(CPU_LIMIT_ADDR, 32'hFFFF_FFFF);
    for (int i = 0; i < 200; i++) offer_random(1'b0);
    drain();

    // into safe mode by either the cpu or the memory route
    if ($urandom_range(0, 1) != 0) begin
      write_budget(CPU_LIMIT_ADDR, 32'd0);
    end else begin
      write_budget(MEM_BUDGET_ADDR, 32'd0);
    end
    for (int i = 0; i < 200; i++) offer_random(1'b0);
    drain();

    // saturation, denied pages and full-range amounts
    write_budget(CPU_LIMIT_ADDR, $urandom);
    write_budget(MEM_BUDGET_ADDR, $urandom);
    offer(MODE_CPU, 32'hFFFF_FFFF, 1'b1, 1'b1);
    offer(MODE_CPU, 32'd1, 1'b0, 1'b0);
    offer(MODE_MEM, 32'hFFFF_FFFF, 1'b0, 1'b0);
    offer(MODE_ALLOC, 32'd0, 1'b1, 1'b0);
    offer(MODE_FREE, 32'd0, 1'b0, 1'b1);
    for (int i = 0; i < 100; i++) offer_random(1'b1);
    drain();

    // back-to-back violations on both counters
    write_budget(CPU_LIMIT_ADDR, 32'd0);
    write_budget(MEM_BUDGET_ADDR, 32'd0);
    no_gaps = 1'b1;
    for (int i = 0; i < FLOOD_ITEMS; i++) begin
      offer(MODE_CPU, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      offer(MODE_MEM, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    drain();
    repeat (8) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
